>>> rtl/rtdct_pkg.sv
// Package for the RTD code to temperature unit: item structs, register map,
// reset values and output limits. No dependencies.
`timescale 1ns / 1ps

package rtdct_pkg;

    typedef struct packed {
        logic [7:0] code_high_byte;
        logic [6:0] code_low_bits;
        logic       sensor_fault;
    } t_in_item;

    typedef struct packed {
        logic signed [16:0] temperature_q6;
        logic               fault_out;
        logic               math_error;
    } t_out_item;

    // control word that travels down the pipeline with each item
    typedef struct packed {
        logic               valid;
        logic               fault;
        logic               quad;
        logic               err;
        logic signed [16:0] lin_temp;
    } t_ctl;

    localparam logic [1:0] REG_REF_RES = 2'd0;
    localparam logic [1:0] REG_NOM_RES = 2'd1;
    localparam logic [1:0] REG_COEFF_A = 2'd2;
    localparam logic [1:0] REG_COEFF_B = 2'd3;

    localparam logic [19:0]        RST_REF_RES = 20'd27520;
    localparam logic [19:0]        RST_NOM_RES = 20'd6400;
    localparam logic [31:0]        RST_COEFF_A = 32'd16785921;
    localparam logic signed [31:0] RST_COEFF_B = -32'sd162551799;

    localparam logic [15:0]        CODE_FULL_SCALE = 16'h7FFF;
    localparam logic signed [16:0] TEMP_MIN_Q6 = -17'sd16384;
    localparam logic signed [16:0] TEMP_MAX_Q6 = 17'sd65535;
    localparam logic signed [20:0] SAT_LO = -21'sd16384;
    localparam logic signed [20:0] SAT_HI = 21'sd65535;

endpackage

>>> rtl/rtd_code_to_temperature_unit.sv
// Throughput: one item per cycle; busy is always low, nothing can stall.
// Depth is set by the 64-bit divider by r0 in the discriminant (16 stages), the
// 32-bit root (16 stages) and the 20-bit temperature divider (5 stages).
// Reset: synchronous, active low; clears valid bits and loads register defaults.
`timescale 1ns / 1ps

// RTD code to temperature unit: fully pipelined inverse quadratic.
// Depends on rtdct_pkg.
module rtd_code_to_temperature_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rtdct_pkg::t_in_item   i_item,
    output logic                  o_result_valid,
    output rtdct_pkg::t_out_item  o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int D1_STAGES = 16;
    localparam int SQ_STAGES = 16;
    localparam int D2_STAGES = 5;
    localparam int ST_DIFF   = 3;
    localparam int ST_D1     = 4;
    localparam int ST_SQ0    = ST_D1 + D1_STAGES + 1;
    localparam int ST_NUM    = ST_SQ0 + SQ_STAGES + 1;
    localparam int ST_MAG    = ST_NUM + 1;
    localparam int ST_D2     = ST_MAG + 1;
    localparam int LAST      = ST_D2 + D2_STAGES;

    // configuration
    logic [19:0]        r_ref;
    logic [19:0]        r_nom;
    logic [31:0]        r_a;
    logic signed [31:0] r_b;
    logic [31:0]        r_b_mag;

    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= rtdct_pkg::RST_REF_RES;
            r_nom <= rtdct_pkg::RST_NOM_RES;
            r_a   <= rtdct_pkg::RST_COEFF_A;
            r_b   <= rtdct_pkg::RST_COEFF_B;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                rtdct_pkg::REG_REF_RES: r_ref <= pwdata[19:0];
                rtdct_pkg::REG_NOM_RES: r_nom <= pwdata[19:0];
                rtdct_pkg::REG_COEFF_A: r_a   <= pwdata;
                rtdct_pkg::REG_COEFF_B: r_b   <= $signed(pwdata);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_mag <= r_b[31] ? 32'(-r_b) : 32'(r_b);
    end

    always_comb begin
        unique case (paddr[3:2])
            rtdct_pkg::REG_REF_RES: prdata = {12'd0, r_ref};
            rtdct_pkg::REG_NOM_RES: prdata = {12'd0, r_nom};
            rtdct_pkg::REG_COEFF_A: prdata = r_a;
            rtdct_pkg::REG_COEFF_B: prdata = r_b;
            default:                prdata = '0;
        endcase
    end

    // control line
    rtdct_pkg::t_ctl r_ctl [0:LAST];
    rtdct_pkg::t_ctl n_ctl [0:LAST];
    logic [11:0]     n_lin_deg;
    logic [63:0]     n_disc;

    assign n_lin_deg = {2'b00, i_item.code_high_byte, i_item.code_low_bits[6:5]} - 12'd256;

    always_comb begin
        n_ctl[0].valid    = start;
        n_ctl[0].fault    = i_item.sensor_fault;
        n_ctl[0].quad     = 1'b0;
        n_ctl[0].err      = 1'b0;
        n_ctl[0].lin_temp = $signed({n_lin_deg[10:0], 6'b000000});
        for (int i = 1; i <= LAST; i++) begin
            n_ctl[i] = r_ctl[i-1];
        end
        n_ctl[ST_DIFF].quad = (r_r2 >= r_nom);
        n_ctl[ST_DIFF].err  = (r_b == '0) || (r_nom == '0);
        n_ctl[ST_SQ0].err   = r_ctl[ST_SQ0-1].err | n_disc[63];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= LAST; i++) begin
                r_ctl[i].valid <= 1'b0;
            end
        end else begin
            r_ctl <= n_ctl;
        end
    end

    // resistance: code * ref / 32767
    logic [14:0] r_code0;
    logic [34:0] r_x1;
    logic [19:0] r_r2;
    logic [19:0] r_diff3;
    logic [19:0] n_q0;
    logic [20:0] n_rem;
    logic [5:0]  n_q1;
    logic [15:0] n_rem2;
    logic [20:0] n_r;

    always_comb begin
        n_q0   = r_x1[34:15];
        n_rem  = {1'b0, n_q0} + {6'd0, r_x1[14:0]};
        n_q1   = n_rem[20:15];
        n_rem2 = {1'b0, n_rem[14:0]} + {10'd0, n_q1};
        n_r    = {1'b0, n_q0} + {15'd0, n_q1}
               + {20'd0, (n_rem2 >= rtdct_pkg::CODE_FULL_SCALE)};
    end

    always_ff @(posedge i_clk) begin
        r_code0 <= {i_item.code_high_byte, i_item.code_low_bits};
        r_x1    <= 35'(r_code0) * 35'(r_ref);
        r_r2    <= n_r[19:0];
        r_diff3 <= r_r2 - r_nom;
    end

    // |b| * (R - r0) * 1024 / r0
    logic [63:0] r_d1_qn  [0:D1_STAGES];
    logic [19:0] r_d1_rem [0:D1_STAGES];
    logic [55:0] r_d1_sq  [0:D1_STAGES];
    logic [51:0] n_prod;
    logic [63:0] n_asq;

    assign n_prod = 52'(r_b_mag) * 52'(r_diff3);
    assign n_asq  = 64'(r_a) * 64'(r_a);

    always_ff @(posedge i_clk) begin
        r_d1_qn[0]  <= {2'b00, n_prod, 10'd0};
        r_d1_rem[0] <= '0;
        r_d1_sq[0]  <= n_asq[63:8];
    end

    for (genvar k = 1; k <= D1_STAGES; k++) begin : g_d1
        logic [63:0] n_qn;
        logic [19:0] n_rm;
        always_comb begin
            logic [20:0] t_rem;
            n_qn = r_d1_qn[k-1];
            n_rm = r_d1_rem[k-1];
            for (int j = 0; j < 4; j++) begin
                t_rem = {n_rm, n_qn[63]};
                if (t_rem >= {1'b0, r_nom}) begin
                    n_rm = 20'(t_rem - {1'b0, r_nom});
                    n_qn = {n_qn[62:0], 1'b1};
                end else begin
                    n_rm = t_rem[19:0];
                    n_qn = {n_qn[62:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_d1_qn[k]  <= n_qn;
            r_d1_rem[k] <= n_rm;
            r_d1_sq[k]  <= r_d1_sq[k-1];
        end
    end

    // discriminant, Q56
    assign n_disc = r_b[31] ? ({8'd0, r_d1_sq[D1_STAGES]} - r_d1_qn[D1_STAGES])
                            : ({8'd0, r_d1_sq[D1_STAGES]} + r_d1_qn[D1_STAGES]);

    // integer square root, two bits a stage
    logic [63:0] r_sq_v    [0:SQ_STAGES];
    logic [34:0] r_sq_rem  [0:SQ_STAGES];
    logic [31:0] r_sq_root [0:SQ_STAGES];

    always_ff @(posedge i_clk) begin
        r_sq_v[0]    <= n_disc;
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
    end

    for (genvar k = 1; k <= SQ_STAGES; k++) begin : g_sq
        logic [63:0] n_v;
        logic [34:0] n_rm;
        logic [31:0] n_rt;
        always_comb begin
            logic [34:0] t_rem;
            logic [34:0] t_try;
            n_v  = r_sq_v[k-1];
            n_rm = r_sq_rem[k-1];
            n_rt = r_sq_root[k-1];
            for (int j = 0; j < 2; j++) begin
                t_rem = {n_rm[32:0], n_v[63:62]};
                t_try = {1'b0, n_rt, 2'b01};
                n_v   = {n_v[61:0], 2'b00};
                if (t_rem >= t_try) begin
                    n_rm = t_rem - t_try;
                    n_rt = {n_rt[30:0], 1'b1};
                end else begin
                    n_rm = t_rem;
                    n_rt = {n_rt[30:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_sq_v[k]    <= n_v;
            r_sq_rem[k]  <= n_rm;
            r_sq_root[k] <= n_rt;
        end
    end

    // numerator s*16 - a, then magnitude and quotient sign
    logic signed [37:0] r_num6;
    logic [37:0]        r_mag7;
    logic               r_qneg7;

    always_ff @(posedge i_clk) begin
        r_num6  <= $signed({2'b00, r_sq_root[SQ_STAGES], 4'b0000}) - $signed({6'd0, r_a});
        r_mag7  <= r_num6[37] ? 38'(-r_num6) : 38'(r_num6);
        r_qneg7 <= r_num6[37] ^ r_b[31];
    end

    // |num| * 2^21 / |b|, 20 quotient bits, overflow flagged up front
    logic [31:0] r_d2_rem  [0:D2_STAGES];
    logic [19:0] r_d2_q    [0:D2_STAGES];
    logic        r_d2_sat  [0:D2_STAGES];
    logic        r_d2_qneg [0:D2_STAGES];

    always_ff @(posedge i_clk) begin
        r_d2_rem[0]  <= {r_mag7[30:0], 1'b0};
        r_d2_q[0]    <= '0;
        r_d2_sat[0]  <= ({r_mag7, 1'b0} >= {7'd0, r_b_mag});
        r_d2_qneg[0] <= r_qneg7;
    end

    for (genvar k = 1; k <= D2_STAGES; k++) begin : g_d2
        logic [31:0] n_rm;
        logic [19:0] n_q;
        always_comb begin
            logic [32:0] t_rem;
            n_rm = r_d2_rem[k-1];
            n_q  = r_d2_q[k-1];
            for (int j = 0; j < 4; j++) begin
                t_rem = {n_rm, 1'b0};
                if (t_rem >= {1'b0, r_b_mag}) begin
                    n_rm = 32'(t_rem - {1'b0, r_b_mag});
                    n_q  = {n_q[18:0], 1'b1};
                end else begin
                    n_rm = t_rem[31:0];
                    n_q  = {n_q[18:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_d2_rem[k]  <= n_rm;
            r_d2_q[k]    <= n_q;
            r_d2_sat[k]  <= r_d2_sat[k-1];
            r_d2_qneg[k] <= r_d2_qneg[k-1];
        end
    end

    // sign, clamp, branch select
    logic signed [20:0] n_val;
    logic signed [16:0] n_temp;
    logic               n_err;

    always_comb begin
        n_val = r_d2_qneg[D2_STAGES] ? -$signed({1'b0, r_d2_q[D2_STAGES]})
                                     : $signed({1'b0, r_d2_q[D2_STAGES]});
        n_err = 1'b0;
        priority if (!r_ctl[LAST].quad) begin
            n_temp = r_ctl[LAST].lin_temp;
        end else if (r_ctl[LAST].err) begin
            n_temp = '0;
            n_err  = 1'b1;
        end else if (r_d2_sat[D2_STAGES]) begin
            n_temp = r_d2_qneg[D2_STAGES] ? rtdct_pkg::TEMP_MIN_Q6 : rtdct_pkg::TEMP_MAX_Q6;
        end else if (n_val < rtdct_pkg::SAT_LO) begin
            n_temp = rtdct_pkg::TEMP_MIN_Q6;
        end else if (n_val > rtdct_pkg::SAT_HI) begin
            n_temp = rtdct_pkg::TEMP_MAX_Q6;
        end else begin
            n_temp = n_val[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= r_ctl[LAST].valid;
        end
        o_result.temperature_q6 <= n_temp;
        o_result.fault_out      <= r_ctl[LAST].fault;
        o_result.math_error     <= n_err;
    end

    // checks
    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start, LAST + 2))
        else $error("result without an item accepted at the expected time");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.math_error |-> o_result.temperature_q6 == '0)
        else $error("math error with nonzero temperature");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.temperature_q6 >= rtdct_pkg::TEMP_MIN_Q6)
                        && (o_result.temperature_q6 <= rtdct_pkg::TEMP_MAX_Q6))
        else $error("temperature out of range");

    a_d1_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[ST_SQ0-1].valid && r_ctl[ST_SQ0-1].quad && !r_ctl[ST_SQ0-1].err
        |-> r_d1_rem[D1_STAGES] < r_nom)
        else $error("resistance divider remainder not below divisor");

    a_sq_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[ST_NUM-1].valid |-> r_sq_rem[SQ_STAGES] <= {2'b00, r_sq_root[SQ_STAGES], 1'b0})
        else $error("square root remainder above bound");

endmodule

>>> tb/rtd_code_to_temperature_unit_tb.sv
// Testbench for rtd_code_to_temperature_unit: drives conversion items and
// APB register writes, predicts each temperature result and checks it.
// Depends on rtdct_pkg and the unit RTL.
`timescale 1ns / 1ps

module rtd_code_to_temperature_unit_tb;

    localparam int LATENCY = 46;
    localparam int STALL_LIMIT = 5000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    rtdct_pkg::t_in_item  i_item;
    logic                 o_result_valid;
    rtdct_pkg::t_out_item o_result;
    logic                 psel, penable, pwrite;
    logic [3:0]           paddr;
    logic [31:0]          pwdata, prdata;
    logic                 pready;

    rtd_code_to_temperature_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_result_valid(o_result_valid), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [19:0]        ref_res;
    logic [19:0]        nom_res;
    logic [31:0]        coeff_a;
    logic signed [31:0] coeff_b;

    rtdct_pkg::t_out_item temp_pending[$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        results_seen = 0;
    int        quad_errors = 0;
    int        idle_cycles = 0;
    bit        allow_idle = 1'b1;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic rtdct_pkg::t_out_item predict_temperature(rtdct_pkg::t_in_item it);
        rtdct_pkg::t_out_item res;
        longint unsigned code, r, au;
        longint          b, a, sq, diff, lin, disc, s, num, temp, nom;
        bit              err;
        code = {49'd0, it.code_high_byte, it.code_low_bits};
        r = (code * {44'd0, ref_res}) / 64'd32767;
        nom = longint'({44'd0, nom_res});
        temp = 0;
        err = 1'b0;
        if (r >= {44'd0, nom_res}) begin
            b = longint'(coeff_b);
            if (b == 0 || nom == 0) begin
                err = 1'b1;
            end else begin
                au = {32'd0, coeff_a};
                a = longint'(au);
                sq = longint'((au * au) >> 8);
                diff = longint'(r) - nom;
                lin = (b * diff * 1024) / nom;
                disc = sq + lin;
                if (disc < 0) begin
                    err = 1'b1;
                end else begin
                    s = longint'(int_sqrt(longint'(disc)));
                    num = s * 16 - a;
                    temp = (num * 2097152) / b;
                end
            end
        end else begin
            temp = (longint'(code >> 5) - 256) * 64;
        end
        if (temp < -16384) temp = -16384;
        if (temp > 65535) temp = 65535;
        res.temperature_q6 = temp[16:0];
        res.fault_out = it.sensor_fault;
        res.math_error = err;
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        rtdct_pkg::t_out_item want;
        if (i_rst_n && o_result_valid) begin
            results_seen++;
            if (temp_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", o_result);
            end else begin
                want = temp_pending.pop_front();
                if (o_result.math_error) quad_errors++;
                if (o_result.temperature_q6 !== want.temperature_q6 ||
                    o_result.fault_out !== want.fault_out ||
                    o_result.math_error !== want.math_error) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected temp %0d fault %b err %b, got %0d %b %b",
                                 want.temperature_q6, want.fault_out, want.math_error,
                                 o_result.temperature_q6, o_result.fault_out,
                                 o_result.math_error);
                end
            end
        end
    end

    // watchdog on cycles with no item, result or register access
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("rtd_code_to_temperature_unit_tb NOT OK");
            $finish;
        end
    end

    task automatic idle_burst();
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_item(logic [7:0] hi, logic [6:0] lo, logic fault);
        rtdct_pkg::t_in_item it;
        it.code_high_byte = hi;
        it.code_low_bits = lo;
        it.sensor_fault = fault;
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        temp_pending.push_back(predict_temperature(it));
        items_sent++;
        idle_burst();
    endtask

    task automatic send_code(logic [14:0] code, logic fault);
        send_item(code[14:7], code[6:0], fault);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (temp_pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            rtdct_pkg::REG_REF_RES: ref_res = value[19:0];
            rtdct_pkg::REG_NOM_RES: nom_res = value[19:0];
            rtdct_pkg::REG_COEFF_A: coeff_a = value;
            rtdct_pkg::REG_COEFF_B: coeff_b = value;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [19:0] rr, logic [19:0] nr, logic [31:0] ca,
                              logic signed [31:0] cb);
        drain();
        write_reg(rtdct_pkg::REG_REF_RES, {12'd0, rr});
        write_reg(rtdct_pkg::REG_NOM_RES, {12'd0, nr});
        write_reg(rtdct_pkg::REG_COEFF_A, ca);
        write_reg(rtdct_pkg::REG_COEFF_B, cb);
    endtask

    task automatic test_default_codes();
        send_code(15'd0, 1'b0);
        send_code(15'h7FFF, 1'b1);
        send_item(8'hFF, 7'd0, 1'b0);
        send_item(8'd0, 7'h7F, 1'b1);
        send_code(15'd7619, 1'b0);
        send_code(15'd7620, 1'b0);
        send_code(15'd7621, 1'b1);
        send_code(15'd16384, 1'b0);
        send_code(15'd31, 1'b0);
        send_code(15'd32, 1'b1);
    endtask

    task automatic test_math_errors();
        set_config(20'd27520, 20'd6400, 32'd16785921, 32'sd0);
        send_code(15'd20000, 1'b0);
        send_code(15'd1000, 1'b1);
        set_config(20'd27520, 20'd6400, 32'd1000, -32'sd2147483648);
        send_code(15'h7FFF, 1'b0);
        send_code(15'd9000, 1'b0);
        set_config(20'd27520, 20'd0, 32'd16785921, rtdct_pkg::RST_COEFF_B);
        send_code(15'd0, 1'b0);
        send_code(15'd12345, 1'b1);
    endtask

    task automatic test_extreme_registers();
        set_config(20'd0, 20'd1, 32'd0, 32'sd1);
        send_code(15'h7FFF, 1'b0);
        send_code(15'd100, 1'b1);
        set_config(20'hFFFFF, 20'd1, 32'hFFFFFFFF, 32'sd2147483647);
        send_code(15'h7FFF, 1'b0);
        send_code(15'd1, 1'b1);
        set_config(20'hFFFFF, 20'hFFFFF, 32'd16785921, -32'sd1);
        send_code(15'h7FFF, 1'b0);
        send_code(15'h7FFE, 1'b0);
        send_code(15'd0, 1'b1);
    endtask

    task automatic test_random_phase(int count, bit wild);
        logic [19:0]        rr, nr;
        logic [31:0]        ca;
        logic signed [31:0] cb;
        if (wild) begin
            rr = 20'($urandom);
            nr = 20'($urandom_range(1, 20'hFFFFF));
            ca = $urandom;
            cb = $urandom;
        end else begin
            rr = 20'($urandom_range(16000, 40000));
            nr = 20'($urandom_range(5000, 8000));
            ca = $urandom_range(15000000, 18000000);
            cb = -$signed({1'b0, 31'($urandom_range(100000000, 200000000))});
        end
        set_config(rr, nr, ca, cb);
        for (int n = 0; n < count; n++) begin
            send_code(15'($urandom), 1'($urandom));
            if (n == count / 2 && $urandom_range(0, 1) == 0) drain();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        ref_res = rtdct_pkg::RST_REF_RES;
        nom_res = rtdct_pkg::RST_NOM_RES;
        coeff_a = rtdct_pkg::RST_COEFF_A;
        coeff_b = rtdct_pkg::RST_COEFF_B;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_codes();
        test_math_errors();
        test_extreme_registers();
        for (int p = 0; p < 8; p++) test_random_phase(110, p % 3 == 2);
        drain();
        allow_idle = 1'b0;
        test_random_phase(150, 1'b0);
        drain();
        repeat (LATENCY) @(posedge i_clk);

        $display("Sent %0d items over default, extreme and random register settings;",
                 items_sent);
        $display("checked %0d temperatures, %0d of them flagged as math errors.",
                 results_seen, quad_errors);
        if (mismatches == 0 && temp_pending.size() == 0) begin
            $display("rtd_code_to_temperature_unit_tb OK");
        end else begin
            $display("rtd_code_to_temperature_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/rtdct_pkg.sv
rtl/rtd_code_to_temperature_unit.sv
tb/rtd_code_to_temperature_unit_tb.sv
